FILE: src/jac_pkg.sv
// Shared types, constants and the control program of the joystick axis conditioner.
// Depends on nothing; every other source file imports it.
package jac_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;

  localparam int SAMPLE_W = 10;
  localparam int RANGE_W  = 11;
  localparam int POS_W    = 8;
  localparam int MODE_W   = 2;
  localparam int WEIGHT_W = 9;
  localparam int CFG_IDX_W = 2;

  // Operand widths of the range map divide.
  localparam int MAP_NUM_W = 19;
  localparam int MAP_DEN_W = 11;
  localparam int MAP_Q_W   = 18;

  localparam logic [SAMPLE_W-1:0] MID_RST     = 10'd512;
  localparam logic [RANGE_W-1:0]  RANGE_MIN   = 11'sd1;
  localparam logic [RANGE_W-1:0]  CODE_MAX    = 11'sd1023;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = 9'd128;
  localparam logic signed [POS_W-1:0] POS_MAX = 8'sd100;
  localparam logic signed [POS_W-1:0] POS_MIN = -8'sd100;

  localparam logic [MODE_W-1:0] MODE_RAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RC_WEIGHT   = 2'd1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Datapath actions.
  localparam logic [2:0] ACT_NOP        = 3'd0;
  localparam logic [2:0] ACT_WAIT       = 3'd1;
  localparam logic [2:0] ACT_MEAN_GO    = 3'd2;
  localparam logic [2:0] ACT_MEAN_LATCH = 3'd3;
  localparam logic [2:0] ACT_FILT_CAL   = 3'd4;
  localparam logic [2:0] ACT_MAP_GO     = 3'd5;
  localparam logic [2:0] ACT_MAP_LATCH  = 3'd6;
  localparam logic [2:0] ACT_EMIT       = 3'd7;

  // Jump conditions.
  localparam logic [1:0] COND_NEXT      = 2'd0;
  localparam logic [1:0] COND_ALWAYS    = 2'd1;
  localparam logic [1:0] COND_NO_MEAN   = 2'd2;
  localparam logic [1:0] COND_ZERO_SPAN = 2'd3;

  localparam int STEP_W = 4;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_X_MEAN = 4'd1;
  localparam logic [STEP_W-1:0] STEP_X_MLAT = 4'd2;
  localparam logic [STEP_W-1:0] STEP_X_FILT = 4'd3;
  localparam logic [STEP_W-1:0] STEP_X_MAP  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_X_PLAT = 4'd5;
  localparam logic [STEP_W-1:0] STEP_Y_MEAN = 4'd6;
  localparam logic [STEP_W-1:0] STEP_Y_MLAT = 4'd7;
  localparam logic [STEP_W-1:0] STEP_Y_FILT = 4'd8;
  localparam logic [STEP_W-1:0] STEP_Y_MAP  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_Y_PLAT = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd11;

  typedef struct packed {
    logic              axis;
    logic [2:0]        act;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } jac_uop_t;

  typedef struct packed {
    logic hold;
    logic no_mean;
    logic zero_span;
  } jac_status_t;

  // Control store. A taken condition jumps to target, otherwise the step advances.
  function automatic jac_uop_t jac_program(input logic [STEP_W-1:0] step);
    jac_uop_t u;
    case (step)
      STEP_WAIT:   u = '{AXIS_X, ACT_WAIT,       COND_NEXT,      STEP_WAIT};
      STEP_X_MEAN: u = '{AXIS_X, ACT_MEAN_GO,    COND_NO_MEAN,   STEP_X_FILT};
      STEP_X_MLAT: u = '{AXIS_X, ACT_MEAN_LATCH, COND_NEXT,      STEP_WAIT};
      STEP_X_FILT: u = '{AXIS_X, ACT_FILT_CAL,   COND_NEXT,      STEP_WAIT};
      STEP_X_MAP:  u = '{AXIS_X, ACT_MAP_GO,     COND_ZERO_SPAN, STEP_Y_MEAN};
      STEP_X_PLAT: u = '{AXIS_X, ACT_MAP_LATCH,  COND_NEXT,      STEP_WAIT};
      STEP_Y_MEAN: u = '{AXIS_Y, ACT_MEAN_GO,    COND_NO_MEAN,   STEP_Y_FILT};
      STEP_Y_MLAT: u = '{AXIS_Y, ACT_MEAN_LATCH, COND_NEXT,      STEP_WAIT};
      STEP_Y_FILT: u = '{AXIS_Y, ACT_FILT_CAL,   COND_NEXT,      STEP_WAIT};
      STEP_Y_MAP:  u = '{AXIS_Y, ACT_MAP_GO,     COND_ZERO_SPAN, STEP_EMIT};
      STEP_Y_PLAT: u = '{AXIS_Y, ACT_MAP_LATCH,  COND_NEXT,      STEP_WAIT};
      STEP_EMIT:   u = '{AXIS_X, ACT_EMIT,       COND_ALWAYS,    STEP_WAIT};
      default:     u = '{AXIS_X, ACT_NOP,        COND_ALWAYS,    STEP_WAIT};
    endcase
    return u;
  endfunction

endpackage

FILE: src/joystick_axis_conditioner_core.sv
// Top level of the joystick axis conditioner: config registers, datapath and output register.
// Depends on jac_pkg, jac_history, jac_divider and jac_sequencer.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid / s_tready    s_tdata: x_sample, y_sample; s_tuser: kind
//   m_*      out        m_tvalid / m_tready    m_tdata: positions, centers, ranges, span_error
//   cfg_*    in         cfg_we                 cfg_index, cfg_data
//
// A result is valid once its item has run the control program with two serial range map
// divides; the next item is accepted only after the result is emitted.
// A calibrate item, or filter mode 2, adds one history mean step per axis.
// A zero span skips that axis divide. The mean is a reciprocal multiply.
// Reset is synchronous; no clearing pass is needed. The next item is accepted while a result
// waits in the output register; a stalled output holds the sequencer at its last step.
module joystick_axis_conditioner_core import jac_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WEIGHT_W-1:0]   cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // x_sample[9:0], y_sample[19:10], zero fill
  input  logic                  s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // x_pos[7:0], y_pos[15:8], x_center[25:16], y_center[35:26], x_low[46:36],
  // x_high[57:47], y_low[68:58], y_high[79:69], span_error[80], zero fill
  output logic [87:0]           m_tdata
);

  localparam int SUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH);

  // The history mean is floor(sum * MEAN_MUL / 2**MEAN_SH), exact for every SUM_W-bit sum.
  localparam int MEAN_SH = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int MUL_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam logic [63:0] MEAN_MUL_WIDE =
      ((64'd1 << MEAN_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [MUL_W-1:0] MEAN_MUL = MEAN_MUL_WIDE[MUL_W-1:0];

  logic [MODE_W-1:0]   filter_mode;
  logic [WEIGHT_W-1:0] rc_weight;

  jac_uop_t    uop;
  jac_status_t status;

  logic                s_accept;
  logic [SAMPLE_W-1:0] x_new, x_second, y_new, y_second;
  logic [SUM_W-1:0]    x_sum, y_sum;

  logic                kind_r;
  logic                err;
  logic                neg_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic [SAMPLE_W-1:0] v_r;
  logic [SAMPLE_W-1:0] mid [2];
  logic [RANGE_W-1:0]  lo [2];
  logic [RANGE_W-1:0]  hi [2];
  logic [POS_W-1:0]    pos [2];

  logic [SAMPLE_W-1:0] h0_s, h1_s;
  logic [SUM_W-1:0]    sum_s;
  logic [PROD_W-1:0]   mean_prod;
  logic [SAMPLE_W-1:0] mean_q;
  logic [RANGE_W-1:0]  lo_s, hi_s;
  logic [WEIGHT_W-1:0] a_sat, a_inv;
  logic [18:0]         mix;
  logic [SAMPLE_W-1:0] filt;
  logic [11:0]         c_dbl;
  logic [RANGE_W-1:0]  cal_lo, cal_hi;
  logic [11:0]         diff;
  logic [19:0]         num;
  logic [MAP_NUM_W-1:0] num_mag;
  logic [11:0]         span;
  logic [MAP_DEN_W-1:0] span_mag;
  logic                need_mean;

  logic                 div_start, div_busy;
  logic [MAP_NUM_W-1:0] div_num, div_quo;
  logic [MAP_DEN_W-1:0] div_den;
  logic [20:0]          q_signed, p_raw;
  logic [POS_W-1:0]     p_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_RAW;
      rc_weight   <= WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE: filter_mode <= cfg_data[MODE_W-1:0];
        REG_RC_WEIGHT:   rc_weight   <= cfg_data;
        default: ;
      endcase
    end
  end

  jac_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uop    (uop)
  );

  jac_history #(.DEPTH(HISTORY_DEPTH)) u_x_hist (
    .clk    (clk),
    .rst    (rst),
    .push   (s_accept),
    .sample (s_tdata[9:0]),
    .newest (x_new),
    .second (x_second),
    .sum    (x_sum)
  );

  jac_history #(.DEPTH(HISTORY_DEPTH)) u_y_hist (
    .clk    (clk),
    .rst    (rst),
    .push   (s_accept),
    .sample (s_tdata[19:10]),
    .newest (y_new),
    .second (y_second),
    .sum    (y_sum)
  );

  jac_divider #(.NUM_W(MAP_NUM_W), .DEN_W(MAP_DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign s_tready = (uop.act == ACT_WAIT) && !rst;
  assign s_accept = s_tvalid && s_tready;

  // Operands of the axis the current step works on.
  assign h0_s  = (uop.axis == AXIS_Y) ? y_new : x_new;
  assign h1_s  = (uop.axis == AXIS_Y) ? y_second : x_second;
  assign sum_s = (uop.axis == AXIS_Y) ? y_sum : x_sum;
  assign lo_s  = lo[uop.axis];
  assign hi_s  = hi[uop.axis];

  assign mean_prod = PROD_W'(sum_s) * PROD_W'(MEAN_MUL);
  assign mean_q    = mean_prod[MEAN_SH +: SAMPLE_W];

  // Two-tap weighted mix with the weight saturated at one.
  assign a_sat = (rc_weight > WEIGHT_ONE) ? WEIGHT_ONE : rc_weight;
  assign a_inv = WEIGHT_ONE - a_sat;
  assign mix   = 19'(a_sat) * 19'(h1_s) + 19'(a_inv) * 19'(h0_s);

  always_comb begin
    case (filter_mode)
      MODE_RC:   filt = mix[17:8];
      MODE_MEAN: filt = mean_r;
      default:   filt = h0_s;
    endcase
  end

  // Calibrated range symmetric about the new center.
  assign c_dbl = {1'b0, mean_r, 1'b0};

  always_comb begin
    if (mean_r == MID_RST) begin
      cal_lo = RANGE_MIN;
      cal_hi = CODE_MAX;
    end else if (mean_r < MID_RST) begin
      cal_lo = RANGE_MIN;
      cal_hi = RANGE_W'(c_dbl - 12'd1);
    end else begin
      cal_lo = RANGE_W'(c_dbl - {1'b0, CODE_MAX});
      cal_hi = CODE_MAX;
    end
  end

  // Range map operands: (v - low) * 200 over (high - low), as sign and magnitudes.
  assign diff     = {2'b00, v_r} - {lo_s[RANGE_W-1], lo_s};
  assign num      = {{8{diff[11]}}, diff} * 20'd200;
  assign num_mag  = num[19] ? MAP_NUM_W'(-num) : num[MAP_NUM_W-1:0];
  assign span     = {hi_s[RANGE_W-1], hi_s} - {lo_s[RANGE_W-1], lo_s};
  assign span_mag = span[11] ? MAP_DEN_W'(-span) : span[MAP_DEN_W-1:0];

  assign need_mean  = kind_r || (filter_mode == MODE_MEAN);
  assign div_start  = (uop.act == ACT_MAP_GO) && (span != '0);
  assign div_num    = num_mag;
  assign div_den    = span_mag;

  // Quotient back to signed, offset and clamp.
  assign q_signed = neg_r ? -21'(div_quo[MAP_Q_W-1:0]) : 21'(div_quo[MAP_Q_W-1:0]);
  assign p_raw    = q_signed - 21'(POS_MAX);

  always_comb begin
    if ($signed(p_raw) > 21'(POS_MAX)) begin
      p_clamped = POS_MAX;
    end else if ($signed(p_raw) < 21'(POS_MIN)) begin
      p_clamped = POS_MIN;
    end else begin
      p_clamped = p_raw[POS_W-1:0];
    end
  end

  always_comb begin
    status.no_mean   = !need_mean;
    status.zero_span = (span == '0);
    case (uop.act)
      ACT_WAIT:       status.hold = !s_accept;
      ACT_MEAN_LATCH: status.hold = div_busy;
      ACT_MAP_LATCH:  status.hold = div_busy;
      ACT_EMIT:       status.hold = m_tvalid && !m_tready;
      default:        status.hold = 1'b0;
    endcase
  end

  // Calibration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        mid[i] <= MID_RST;
        lo[i]  <= RANGE_MIN;
        hi[i]  <= CODE_MAX;
      end
    end else if ((uop.act == ACT_FILT_CAL) && kind_r) begin
      mid[uop.axis] <= mean_r;
      lo[uop.axis]  <= cal_lo;
      hi[uop.axis]  <= cal_hi;
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    case (uop.act)
      ACT_WAIT: begin
        if (s_accept) begin
          kind_r <= s_tuser;
          err    <= 1'b0;
        end
      end
      ACT_MEAN_LATCH: begin
        if (!div_busy) begin
          mean_r <= mean_q;
        end
      end
      ACT_FILT_CAL: v_r <= filt;
      ACT_MAP_GO: begin
        if (span == '0) begin
          pos[uop.axis] <= '0;
          err           <= 1'b1;
        end else begin
          neg_r <= num[19] ^ span[11];
        end
      end
      ACT_MAP_LATCH: begin
        if (!div_busy) begin
          pos[uop.axis] <= p_clamped;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((uop.act == ACT_EMIT) && !status.hold) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uop.act == ACT_EMIT) && !status.hold) begin
      m_tdata <= {7'b0, err, hi[1], lo[1], hi[0], lo[0], mid[1], mid[0], pos[1], pos[0]};
    end
  end

  a_x_symmetric: assert property (@(posedge clk) disable iff (rst)
      12'({lo[0][RANGE_W-1], lo[0]} + {hi[0][RANGE_W-1], hi[0]}) == {1'b0, mid[0], 1'b0})
    else $error("X range not symmetric about its center");

  a_y_symmetric: assert property (@(posedge clk) disable iff (rst)
      12'({lo[1][RANGE_W-1], lo[1]} + {hi[1][RANGE_W-1], hi[1]}) == {1'b0, mid[1], 1'b0})
    else $error("Y range not symmetric about its center");

  a_flag_span: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tdata[80]) |->
      (m_tdata[46:36] == m_tdata[57:47]) || (m_tdata[68:58] == m_tdata[79:69]))
    else $error("span error raised with nonzero spans");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst) s_tready |-> !div_busy)
    else $error("item accepted while divider is busy");

endmodule

FILE: src/jac_history.sv
// Sample history of one axis: a shift line with newest sample at tap 0 and a running sum.
// Depends on jac_pkg for the sample width and the default depth.
module jac_history import jac_pkg::*; #(
  parameter int DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [SAMPLE_W-1:0]                 sample,
  output logic [SAMPLE_W-1:0]                 newest,
  output logic [SAMPLE_W-1:0]                 second,
  output logic [SAMPLE_W+$clog2(DEPTH)-1:0]   sum
);

  localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);

  logic [SAMPLE_W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        taps[i] <= '0;
      end
      sum <= '0;
    end else if (push) begin
      taps[0] <= sample;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
      sum <= sum + SUM_W'(sample) - SUM_W'(taps[DEPTH-1]);
    end
  end

  assign newest = taps[0];
  assign second = taps[1];

endmodule

FILE: src/jac_divider.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
// Depends on jac_pkg for the default operand widths.
module jac_divider import jac_pkg::*; #(
  parameter int NUM_W = MAP_NUM_W,
  parameter int DEN_W = MAP_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(start && busy))
    else $error("divider started while busy");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with no bits left");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");

endmodule

FILE: src/jac_sequencer.sv
// Step counter and control store; a new datapath control word per cycle unless held.
// Depends on jac_pkg for the control word, status group and program.
module jac_sequencer import jac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  jac_status_t status,
  output jac_uop_t    uop
);

  logic [STEP_W-1:0] step;
  logic              take;

  assign uop = jac_program(step);

  always_comb begin
    case (uop.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NO_MEAN:   take = status.no_mean;
      COND_ZERO_SPAN: take = status.zero_span;
      default:        take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else if (!status.hold) begin
      step <= take ? uop.target : step + STEP_W'(1);
    end
  end

endmodule
